// ===== src/dcrms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrms_pkg: shared definitions of the block DC level and RMS engine
// Sizes and the request/response structures that pass between the top
// level and the shared square-root unit.
// ----------------------------------------------------------------------------
package dcrms_pkg;

    // Block length and sample format.
    localparam int SAMPLE_COUNT = 1024;
    localparam int SAMPLE_W     = 12;
    localparam int SAMPLE_MAX   = 4095;
    localparam int RMS_W        = 20;
    localparam int ADDR_W       = (SAMPLE_COUNT > 2) ? $clog2(SAMPLE_COUNT) : 1;

    // The block length is a power of two, so dividing by it is a right shift.
    localparam int COUNT_LOG2   = $clog2(SAMPLE_COUNT);

    // Accumulator widths, sized so that no block can overflow them.
    localparam int SUM_W = $clog2(SAMPLE_COUNT * SAMPLE_MAX + 1);
    localparam longint SQ_MAX = longint'(SAMPLE_COUNT) * SAMPLE_MAX * SAMPLE_MAX;
    localparam int SQ_W  = $clog2(SQ_MAX + 1);
    localparam int DIFF_W = SAMPLE_W;
    localparam int PROD_W = 2 * DIFF_W;

    // Eight fraction bits on the root means sixteen on the mean square.
    localparam int SCALE_SHIFT = 16;
    localparam int SCL_W       = SQ_W + SCALE_SHIFT - COUNT_LOG2;
    localparam int ROOT_W      = (SCL_W + 1) / 2;
    localparam int OPND_W      = 2 * ROOT_W;

    // Shared subtract/compare unit width: remainder plus two operand bits.
    localparam int UNIT_W    = ROOT_W + 3;
    localparam int STEP_W    = $clog2(ROOT_W + 1);

    // Request to the shared unit.
    typedef struct packed {
        logic              start;
        logic [OPND_W-1:0] operand;
    } unit_req_t;

    // Response from the shared unit.
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] value;
    } unit_rsp_t;

endpackage

// ===== src/dcrms_divsqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrms_divsqrt: shared iterative square root
// One subtract/compare unit forms the digit-by-digit root of the scaled
// mean square, one root bit (two operand bits) per cycle.
// ----------------------------------------------------------------------------
module dcrms_divsqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dcrms_pkg::unit_req_t req,
    output dcrms_pkg::unit_rsp_t rsp
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                               state_reg;
    logic [dcrms_pkg::OPND_W-1:0]         opnd_reg;
    logic [dcrms_pkg::UNIT_W-3:0]         rem_reg;
    logic [dcrms_pkg::ROOT_W-1:0]         quo_reg;
    logic [dcrms_pkg::STEP_W-1:0]         step_reg;
    logic                                 done_reg;

    logic [dcrms_pkg::UNIT_W-1:0]         shifted;
    logic [dcrms_pkg::UNIT_W-1:0]         trial;
    logic [dcrms_pkg::UNIT_W:0]           diff;
    logic                                 fits;

    // Next two operand bits brought down beside the remainder, and the trial
    // value four times the partial root plus one.
    assign shifted = {rem_reg, opnd_reg[dcrms_pkg::OPND_W-1 -: 2]};
    assign trial   = {1'b0, quo_reg, 2'b01};

    // The shared subtract and compare.
    assign diff = {1'b0, shifted} - {1'b0, trial};
    assign fits = ~diff[dcrms_pkg::UNIT_W];

    // Sequencer and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    done_reg <= 1'b0;
                    if (req.start) begin
                        state_reg <= S_RUN;
                        opnd_reg  <= req.operand;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        step_reg  <= dcrms_pkg::STEP_W'(dcrms_pkg::ROOT_W);
                    end
                end
                S_RUN: begin
                    rem_reg  <= fits ? diff[dcrms_pkg::UNIT_W-3:0]
                                     : shifted[dcrms_pkg::UNIT_W-3:0];
                    quo_reg  <= {quo_reg[dcrms_pkg::ROOT_W-2:0], fits};
                    opnd_reg <= {opnd_reg[dcrms_pkg::OPND_W-3:0], 2'b00};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == dcrms_pkg::STEP_W'(1)) begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        done_reg  <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quo_reg;

    // A new request only ever arrives while the unit is idle.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == S_IDLE))
        else $error("divsqrt request while busy");

    // Completion leaves the unit idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == S_IDLE))
        else $error("divsqrt done while still running");

    // A running operation always has steps left.
    a_run_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> (step_reg != '0))
        else $error("divsqrt running with no steps left");

endmodule

// ===== src/block_dc_offset_and_rms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_dc_offset_and_rms: block DC level and true RMS of the AC part
//
//   channel | ports                              | direction | content
//   s_      | s_valid s_ready s_sample           | in        | one 12-bit sample
//   m_      | m_valid m_ready m_dc_mean m_rms_q8 | out       | one result per block
//
// Samples are taken one per cycle while a block fills. The mean is a shift of
// the running sum, taken with the last sample; one memory port then reads back
// each stored sample once, and the root takes one bit per cycle on the shared
// unit. s_ready is low from the last sample of a block until that block's
// result has been handed over to the output register.
// Reset is synchronous and active low; the sample memory is not cleared.
// The next block fills while a result waits on m_ready; a second finished
// result waits in the hand-over state, with s_ready low, until the first is taken.
// ----------------------------------------------------------------------------
module block_dc_offset_and_rms (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dcrms_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dcrms_pkg::SAMPLE_W-1:0]     m_dc_mean,
    output logic [dcrms_pkg::RMS_W-1:0]        m_rms_q8
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SQ,
        ST_ROOT_WAIT,
        ST_HOLD
    } state_t;

    state_t                                state_reg;
    logic [dcrms_pkg::ADDR_W-1:0]          fill_cnt_reg;
    logic [dcrms_pkg::SUM_W-1:0]           sum_reg;
    logic [dcrms_pkg::SUM_W-1:0]           sum_next;
    logic [dcrms_pkg::SAMPLE_W-1:0]        mean_reg;
    logic [dcrms_pkg::SQ_W-1:0]            sq_sum_reg;
    logic [dcrms_pkg::RMS_W-1:0]           root_reg;

    // Read-back pipeline of the squares pass.
    logic [dcrms_pkg::ADDR_W-1:0]          pass_addr_reg;
    logic                                  pass_issue_reg;
    logic                                  rd_vld_reg;
    logic [dcrms_pkg::SAMPLE_W-1:0]        rd_data_reg;
    logic                                  prod_vld_reg;
    logic [dcrms_pkg::PROD_W-1:0]          prod_reg;
    logic [dcrms_pkg::DIFF_W-1:0]          dev;

    logic                                  m_valid_reg;
    logic [dcrms_pkg::SAMPLE_W-1:0]        m_dc_mean_reg;
    logic [dcrms_pkg::RMS_W-1:0]           m_rms_q8_reg;

    dcrms_pkg::unit_req_t                  req_reg;
    dcrms_pkg::unit_rsp_t                  rsp;

    logic [dcrms_pkg::SAMPLE_W-1:0]        sample_mem [dcrms_pkg::SAMPLE_COUNT];

    logic                                  s_take;
    logic                                  last_sample;
    logic                                  root_start;
    logic                                  hand_over;

    assign s_ready     = (state_reg == ST_FILL);
    assign s_take      = s_valid && s_ready;
    assign last_sample = (fill_cnt_reg == dcrms_pkg::ADDR_W'(dcrms_pkg::SAMPLE_COUNT - 1));
    assign sum_next    = sum_reg + dcrms_pkg::SUM_W'(s_sample);

    // The root starts once the squares pass pipeline has drained.
    assign root_start  = (state_reg == ST_SQ) && !pass_issue_reg &&
                         !rd_vld_reg && !prod_vld_reg;

    // A finished result moves to the output once the previous one has gone.
    assign hand_over   = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    // Absolute deviation of a read-back sample from the mean.
    assign dev = (mean_reg >= rd_data_reg) ? (mean_reg - rd_data_reg)
                                           : (rd_data_reg - mean_reg);

    // Sample memory: written while filling, read during the squares pass.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            sample_mem[fill_cnt_reg] <= s_sample;
        end
        rd_data_reg <= sample_mem[pass_addr_reg];
    end

    // Shared square-root unit.
    dcrms_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    // Sequencer, accumulators and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            fill_cnt_reg   <= '0;
            sum_reg        <= '0;
            sq_sum_reg     <= '0;
            pass_addr_reg  <= '0;
            pass_issue_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            req_reg        <= '0;
        end else begin
            // Squares pass pipeline runs whenever there are requests in it.
            rd_vld_reg   <= pass_issue_reg;
            prod_vld_reg <= rd_vld_reg;
            prod_reg     <= dev * dev;
            if (s_take && last_sample) begin
                sq_sum_reg <= '0;
            end else if (prod_vld_reg) begin
                sq_sum_reg <= sq_sum_reg + dcrms_pkg::SQ_W'(prod_reg);
            end

            // Root request: a single-cycle start with the scaled mean square.
            req_reg.start <= root_start;
            if (root_start) begin
                req_reg.operand <= dcrms_pkg::OPND_W'(
                    {sq_sum_reg, dcrms_pkg::SCALE_SHIFT'(0)} >> dcrms_pkg::COUNT_LOG2);
            end

            // Result register: loaded at hand-over, cleared once taken.
            if (hand_over) begin
                m_valid_reg   <= 1'b1;
                m_dc_mean_reg <= mean_reg;
                m_rms_q8_reg  <= root_reg;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end

            unique case (state_reg)
                ST_FILL: begin
                    if (s_take) begin
                        if (last_sample) begin
                            fill_cnt_reg   <= '0;
                            sum_reg        <= '0;
                            mean_reg       <= dcrms_pkg::SAMPLE_W'(
                                sum_next >> dcrms_pkg::COUNT_LOG2);
                            pass_addr_reg  <= '0;
                            pass_issue_reg <= 1'b1;
                            state_reg      <= ST_SQ;
                        end else begin
                            fill_cnt_reg <= fill_cnt_reg + 1'b1;
                            sum_reg      <= sum_next;
                        end
                    end
                end
                ST_SQ: begin
                    if (pass_issue_reg) begin
                        if (pass_addr_reg ==
                            dcrms_pkg::ADDR_W'(dcrms_pkg::SAMPLE_COUNT - 1)) begin
                            pass_issue_reg <= 1'b0;
                        end else begin
                            pass_addr_reg <= pass_addr_reg + 1'b1;
                        end
                    end else if (root_start) begin
                        state_reg <= ST_ROOT_WAIT;
                    end
                end
                ST_ROOT_WAIT: begin
                    if (rsp.done) begin
                        root_reg  <= dcrms_pkg::RMS_W'(rsp.value);
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    // Hand over once the previous result has been taken.
                    if (hand_over) begin
                        state_reg <= ST_FILL;
                    end
                end
                default: state_reg <= ST_FILL;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_dc_mean = m_dc_mean_reg;
    assign m_rms_q8  = m_rms_q8_reg;

    // The memory is never written while the squares pass reads it.
    a_no_write_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |-> (!pass_issue_reg && !rd_vld_reg))
        else $error("sample written during squares pass");

    // A result is raised only from the hand-over state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_HOLD))
        else $error("result raised outside hand-over");

    // The fill counter and running sum are back at zero once a block has been taken in.
    a_fill_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FILL) |-> (fill_cnt_reg == '0 && sum_reg == '0))
        else $error("fill state not cleared after block");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: block DC level and RMS engine, self-checking testbench
// Sends whole blocks of samples through the request channel with random
// gaps and collects the per-block results under random back-pressure. A
// short table of fixed block shapes comes first, some with hand-worked
// results; random blocks of several shapes follow. Every other result is
// checked against a block mean and integer root the bench works out itself.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 2000;
    localparam int DIRECTED_ROWS  = 5;
    localparam int RANDOM_BLOCKS  = 32;
    localparam int MAX_GAP        = 14;
    localparam longint unsigned BLOCK_LEN = dcrms_pkg::SAMPLE_COUNT;

    // Shapes of sample blocks that the sender can produce.
    typedef enum logic [3:0] {
        SHAPE_ZERO,
        SHAPE_FULL,
        SHAPE_ALTERNATE,
        SHAPE_RAMP,
        SHAPE_SPIKE,
        SHAPE_UNIFORM,
        SHAPE_NARROW,
        SHAPE_CONST,
        SHAPE_SQUARE
    } block_shape_t;

    typedef struct packed {
        logic [dcrms_pkg::SAMPLE_W-1:0] dc_mean;
        logic [dcrms_pkg::RMS_W-1:0]    rms_q8;
    } block_result_t;

    // One block of stimulus, with its result typed in where it is obvious.
    typedef struct packed {
        block_shape_t  shape;
        logic          fixed_result;
        block_result_t result;
    } block_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    logic [dcrms_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;
    logic [dcrms_pkg::SAMPLE_W-1:0] m_dc_mean;
    logic [dcrms_pkg::RMS_W-1:0]    m_rms_q8;

    // Shadow of the block being filled, as seen through accepted requests.
    logic [dcrms_pkg::SAMPLE_W-1:0] block_samples [dcrms_pkg::SAMPLE_COUNT];
    int unsigned                    fill_level = 0;
    longint unsigned                block_sum  = 0;

    block_result_t expected_results [$];
    block_row_t    block_plan [$];
    block_row_t    finished_row;
    block_result_t predicted_result;
    block_result_t oldest_result;

    int error_count  = 0;
    int quiet_cycles = 0;
    int rx_wait      = 0;
    bit rx_stall_on  = 1'b1;

    block_dc_offset_and_rms uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_dc_mean (m_dc_mean),
        .m_rms_q8  (m_rms_q8)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mean of the shadow block, then the truncated root of the mean square
    // deviation with eight fraction bits, found by bisection.
    function automatic block_result_t block_mean_and_rms();
        longint unsigned mean_code;
        longint unsigned code;
        longint unsigned deviation;
        longint unsigned square_total;
        longint unsigned scaled;
        longint unsigned root_lo;
        longint unsigned root_hi;
        longint unsigned root_mid;
        block_result_t   r;
        int              i;
        mean_code = block_sum / BLOCK_LEN;
        square_total = 0;
        for (i = 0; i < dcrms_pkg::SAMPLE_COUNT; i++) begin
            code = 64'(block_samples[i[dcrms_pkg::ADDR_W-1:0]]);
            deviation = (mean_code >= code) ? (mean_code - code) : (code - mean_code);
            square_total = square_total + deviation * deviation;
        end
        scaled = (square_total << 16) / BLOCK_LEN;
        // Invariant: root_lo squared <= scaled < root_hi squared.
        root_lo = 0;
        root_hi = 64'd1 << 32;
        while (root_hi - root_lo > 1) begin
            root_mid = (root_lo + root_hi) >> 1;
            if (root_mid * root_mid <= scaled) begin
                root_lo = root_mid;
            end else begin
                root_hi = root_mid;
            end
        end
        r.dc_mean = mean_code[dcrms_pkg::SAMPLE_W-1:0];
        r.rms_q8  = root_lo[dcrms_pkg::RMS_W-1:0];
        return r;
    endfunction

    // Track accepted samples; on the last one of a block, queue its result.
    always @(posedge aclk) begin : sample_tracker
        if (!aresetn) begin
            fill_level   = 0;
            block_sum    = 0;
            quiet_cycles = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (s_valid && s_ready) begin
                block_samples[fill_level[dcrms_pkg::ADDR_W-1:0]] = s_sample;
                block_sum  = block_sum + s_sample;
                fill_level = fill_level + 1;
                if (fill_level == dcrms_pkg::SAMPLE_COUNT) begin
                    predicted_result = block_mean_and_rms();
                    if (block_plan.size() != 0) begin
                        finished_row = block_plan.pop_front();
                        if (finished_row.fixed_result) begin
                            predicted_result = finished_row.result;
                        end
                    end
                    expected_results.push_back(predicted_result);
                    fill_level = 0;
                    block_sum  = 0;
                end
            end
        end
    end

    // Result side: compare each result with the oldest expectation, and,
    // when stalls are on, hold m_ready low for a random wait while a result is offered.
    always @(posedge aclk) begin : result_checker
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = $urandom_range(0, MAX_GAP);
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, dc_mean %0d rms_q8 %0d",
                             $time, m_dc_mean, m_rms_q8);
                    error_count = error_count + 1;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_dc_mean !== oldest_result.dc_mean) begin
                        $display("%0t: dc_mean mismatch, expected %0d, got %0d",
                                 $time, oldest_result.dc_mean, m_dc_mean);
                        error_count = error_count + 1;
                    end
                    if (m_rms_q8 !== oldest_result.rms_q8) begin
                        $display("%0t: rms_q8 mismatch, expected %0d, got %0d",
                                 $time, oldest_result.rms_q8, m_rms_q8);
                        error_count = error_count + 1;
                    end
                end
                rx_wait = rx_stall_on ? $urandom_range(0, MAX_GAP) : 0;
            end else if (m_valid && rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    // Offer one sample after an optional gap and hold it until accepted.
    // This task lowers valid only during a gap before a sample, so back-to-back
    // requests keep it high.
    task automatic send_sample(input logic [dcrms_pkg::SAMPLE_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send one whole block of the given shape.
    task automatic send_block(input block_row_t row, input bit sender_idles);
        int                             idx;
        int                             level_a;
        int                             level_b;
        int                             spread;
        int                             half_period;
        int                             code;
        logic [dcrms_pkg::SAMPLE_W-1:0] value;
        level_a     = $urandom_range(0, dcrms_pkg::SAMPLE_MAX);
        level_b     = $urandom_range(0, dcrms_pkg::SAMPLE_MAX);
        spread      = $urandom_range(1, 64);
        half_period = $urandom_range(1, 64);
        block_plan.push_back(row);
        for (idx = 0; idx < dcrms_pkg::SAMPLE_COUNT; idx++) begin
            case (row.shape)
                SHAPE_ZERO:      value = '0;
                SHAPE_FULL:      value = dcrms_pkg::SAMPLE_W'(dcrms_pkg::SAMPLE_MAX);
                SHAPE_ALTERNATE: begin
                    value = idx[0] ? dcrms_pkg::SAMPLE_W'(dcrms_pkg::SAMPLE_MAX) : '0;
                end
                SHAPE_RAMP: begin
                    value = dcrms_pkg::SAMPLE_W'(idx * dcrms_pkg::SAMPLE_MAX
                                                 / (dcrms_pkg::SAMPLE_COUNT - 1));
                end
                SHAPE_SPIKE: begin
                    value = (idx == dcrms_pkg::SAMPLE_COUNT / 2)
                          ? dcrms_pkg::SAMPLE_W'(dcrms_pkg::SAMPLE_MAX) : '0;
                end
                SHAPE_UNIFORM: begin
                    value = dcrms_pkg::SAMPLE_W'($urandom_range(0, dcrms_pkg::SAMPLE_MAX));
                end
                SHAPE_NARROW: begin
                    // Small noise around a level, clipped at the converter range.
                    code = level_a + int'($urandom_range(0, 2 * spread)) - spread;
                    if (code < 0) begin
                        code = 0;
                    end else if (code > dcrms_pkg::SAMPLE_MAX) begin
                        code = dcrms_pkg::SAMPLE_MAX;
                    end
                    value = dcrms_pkg::SAMPLE_W'(code);
                end
                SHAPE_CONST:     value = dcrms_pkg::SAMPLE_W'(level_a);
                SHAPE_SQUARE: begin
                    value = ((idx / half_period) % 2) ? dcrms_pkg::SAMPLE_W'(level_a)
                                                      : dcrms_pkg::SAMPLE_W'(level_b);
                end
                default:         value = '0;
            endcase
            send_sample(value, sender_idles ? $urandom_range(0, MAX_GAP) : 0);
        end
    endtask

    // Hold off new requests until every queued result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    initial begin : stimulus
        block_row_t directed_rows [DIRECTED_ROWS];
        block_row_t random_row;
        int         blk;
        int         shape_pick;

        // Silence, full scale and the widest swing have obvious results;
        // the ramp and the single spike are left to the predictor.
        directed_rows[0] = '{SHAPE_ZERO,      1'b1, '{12'd0,    20'd0}};
        directed_rows[1] = '{SHAPE_FULL,      1'b1, '{12'd4095, 20'd0}};
        directed_rows[2] = '{SHAPE_ALTERNATE, 1'b1, '{12'd2047, 20'd524160}};
        directed_rows[3] = '{SHAPE_RAMP,      1'b0, '{12'd0,    20'd0}};
        directed_rows[4] = '{SHAPE_SPIKE,     1'b0, '{12'd0,    20'd0}};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (blk = 0; blk < DIRECTED_ROWS; blk++) begin
            rx_stall_on = ($urandom_range(0, 3) != 0);
            send_block(directed_rows[blk], $urandom_range(0, 3) != 0);
        end
        drain_results();

        // Random blocks, mostly of random shapes, with occasional pauses
        // until the engine has delivered everything it owes.
        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            shape_pick = $urandom_range(0, 11);
            random_row.shape = (shape_pick > int'(SHAPE_SQUARE)) ? SHAPE_UNIFORM
                                                                 : block_shape_t'(shape_pick);
            random_row.fixed_result = 1'b0;
            random_row.result       = '0;
            rx_stall_on = ($urandom_range(0, 3) != 0);
            send_block(random_row, $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("block_dc_offset_and_rms test passed");
        end else begin
            $display("block_dc_offset_and_rms test failed");
        end
        $finish;
    end

    // End the run if neither channel moves a request for too long.
    initial begin : watchdog
        do @(posedge aclk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("block_dc_offset_and_rms test failed");
        $finish;
    end

endmodule
